// ===== sv/sitoa_pkg.sv =====
// sitoa_pkg: constants, types and controller/datapath interface structs
// for the signed integer to decimal ascii converter
// no dependencies
`timescale 1ns / 1ps

package sitoa_pkg;

  // width of the signed input value
  localparam int VALUE_BITS = 16;
  // input tdata width, rounded up to whole bytes
  localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;

  // number of decimal digits needed for the largest magnitude 2^(VALUE_BITS-1)
  function automatic int calc_digits(input int bits);
    longint unsigned lim;
    longint unsigned pw;
    int n;
    lim = 64'd1 << (bits - 1);
    pw = 64'd10;
    n = 1;
    while (pw <= lim) begin
      pw = pw * 64'd10;
      n++;
    end
    return n;
  endfunction

  localparam int NDIG = calc_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * 4;
  localparam int PTR_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  // ascii codes
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO = 8'd48;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SETPTR,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture input value, clear bcd
    logic shift;       // one double-dabble step
    logic set_ptr;     // point at the top nonzero digit
    logic emit_sign;   // send a minus sign
    logic emit_digit;  // send the pointed digit, step pointer down
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;    // output register can take a new char
    logic neg;         // captured value was negative
    logic ptr_zero;    // pointer is at the units digit
  } sts_t;

endpackage

// ===== sv/sitoa_dp.sv =====
// sitoa_dp: datapath with magnitude, bcd shift register, digit pointer
// and the output register; depends on sitoa_pkg
`timescale 1ns / 1ps

module sitoa_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sitoa_pkg::DATA_W-1:0]    in_data_i,
  input  sitoa_pkg::cmd_t                 cmd_i,
  output sitoa_pkg::sts_t                 sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [7:0]                      out_char_o,
  output logic                            out_last_o
);
  import sitoa_pkg::*;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic                  ovalid_q, ovalid_d;
  logic [7:0]            ochar_q, ochar_d;
  logic                  olast_q, olast_d;

  logic [VALUE_BITS-1:0] raw;
  logic [BCD_W-1:0]      bcd_adj;
  logic [PTR_W-1:0]      top_idx;
  logic [3:0]            cur_dig;

  assign raw = in_data_i[VALUE_BITS-1:0];

  // add-3 correction on every digit of five or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // highest nonzero digit, units digit when all are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        top_idx = PTR_W'(i);
      end
    end
  end

  assign cur_dig = bcd_q[ptr_q*4 +: 4];

  // conversion registers
  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      neg_d = raw[VALUE_BITS-1];
      // two's complement negation; the most negative value maps to its true magnitude
      mag_d = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
      bcd_d = '0;
    end
    if (cmd_i.shift) begin
      {bcd_d, mag_d} = {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
    end
    if (cmd_i.set_ptr) begin
      ptr_d = top_idx;
    end
    if (cmd_i.emit_digit && (ptr_q != '0)) begin
      ptr_d = ptr_q - PTR_W'(1);
    end
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q;
    ochar_d = ochar_q;
    olast_d = olast_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (cmd_i.emit_sign) begin
      ovalid_d = 1'b1;
      ochar_d = CHAR_MINUS;
      olast_d = 1'b0;
    end else if (cmd_i.emit_digit) begin
      ovalid_d = 1'b1;
      ochar_d = CHAR_ZERO + {4'd0, cur_dig};
      olast_d = (ptr_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
    ptr_q <= ptr_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  // status to the controller
  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign sts_o.neg = neg_q;
  assign sts_o.ptr_zero = (ptr_q == '0);

  assign out_valid_o = ovalid_q;
  assign out_char_o = ochar_q;
  assign out_last_o = olast_q;

endmodule

// ===== sv/sitoa_ctrl.sv =====
// sitoa_ctrl: controller state machine and shift counter
// depends on sitoa_pkg
`timescale 1ns / 1ps

module sitoa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sitoa_pkg::sts_t sts_i,
  output sitoa_pkg::cmd_t cmd_o
);
  import sitoa_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_SETPTR;
        end
      end
      ST_SETPTR: begin
        cmd_o.set_ptr = 1'b1;
        state_d = sts_i.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.ptr_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid_i/tready_o    tdata[15:0] value (signed)
// m_axis    out  m_axis_tvalid_o/tready_i    tdata[7:0] char_code, tlast last
//
// one value takes a load step in idle, VALUE_BITS double-dabble shift steps, one
// pointer step and then one step per character while the output is free.
// the shift loop of the bcd converter is the longest part of that work.
// reset clears the controller and the output valid; a new value is taken only
// in idle, the last character may still wait in the output register then.
// a stalled output holds the converter on the current character.
// top level: joins sitoa_ctrl and sitoa_dp; depends on sitoa_pkg
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [sitoa_pkg::DATA_W-1:0] s_axis_tdata_i,   // value
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,   // char_code
  output logic                         m_axis_tlast_o
);
  import sitoa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sitoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sitoa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== sv/sitoa_checker.sv =====
// sitoa_checker: port-level assertions for signed_int_to_decimal_ascii
// and its bind statement; depends on sitoa_pkg
`timescale 1ns / 1ps

module sitoa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_valid_i,
  input logic                         s_ready_i,
  input logic                         m_valid_i,
  input logic                         m_ready_i,
  input logic [7:0]                   m_data_i,
  input logic                         m_last_i
);
  import sitoa_pkg::*;

  logic s_fire;
  assign s_fire = s_valid_i && s_ready_i;

  // stalled output item holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i) && $stable(m_last_i))
    else $error("output item changed while stalled");

  // only minus and decimal digits leave the block
  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> (m_data_i == CHAR_MINUS) ||
                  ((m_data_i >= CHAR_ZERO) && (m_data_i <= (CHAR_ZERO + 8'd9))))
    else $error("output char out of range");

  // a minus sign never ends the text
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && (m_data_i == CHAR_MINUS) |-> !m_last_i)
    else $error("minus sign flagged last");

  // converter is busy right after taking a value
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_ready_i)
    else $error("input ready while converting");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid_i),
  .s_ready_i (s_axis_tready_o),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o),
  .m_last_i  (m_axis_tlast_o)
);

// ===== tb/signed_int_to_decimal_ascii_test.sv =====
// testbench for signed_int_to_decimal_ascii: streams signed values in and checks
// every ascii character and tlast flag against a local prediction
// depends on sitoa_pkg and the signed_int_to_decimal_ascii rtl
`timescale 1ns / 1ps

// one expected output character
typedef struct packed {
  logic [7:0] code;
  logic       last;
} ascii_char_t;

// holds the characters still owed by the block and compares arrivals
class ascii_scoreboard;
  ascii_char_t pending[$];
  int          errors;
  int          values_seen;
  int          negatives_seen;
  int          chars_seen;

  function new();
    errors = 0;
    values_seen = 0;
    negatives_seen = 0;
    chars_seen = 0;
  endfunction

  task report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // turn one accepted input word into its decimal text
  task note_value(input logic [sitoa_pkg::DATA_W-1:0] word);
    logic [sitoa_pkg::VALUE_BITS-1:0] raw;
    logic                             neg;
    longint unsigned                  mag;
    logic [3:0]                       digit_q[$];
    ascii_char_t                      ch;
    raw = word[sitoa_pkg::VALUE_BITS-1:0];
    neg = raw[sitoa_pkg::VALUE_BITS-1];
    // true magnitude, so the most negative value does not wrap
    mag = neg ? ((64'd1 << sitoa_pkg::VALUE_BITS) - longint'(raw)) : longint'(raw);
    do begin
      digit_q.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      ch.code = sitoa_pkg::CHAR_MINUS;
      ch.last = 1'b0;
      pending.push_back(ch);
      negatives_seen++;
    end
    // most significant digit first, flag on the units digit
    for (int i = 0; i < digit_q.size(); i++) begin
      ch.code = sitoa_pkg::CHAR_ZERO + 8'(digit_q[i]);
      ch.last = (i == digit_q.size() - 1);
      pending.push_back(ch);
    end
    values_seen++;
  endtask

  // compare one accepted output item with the oldest expectation
  task check_char(input logic [7:0] code, input logic last);
    ascii_char_t want;
    chars_seen++;
    if (pending.size() == 0) begin
      report($sformatf("unexpected char 0x%02h last=%0b", code, last));
    end else begin
      want = pending.pop_front();
      if (code !== want.code)
        report($sformatf("char 0x%02h, expected 0x%02h", code, want.code));
      if (last !== want.last)
        report($sformatf("tlast %0b, expected %0b (char 0x%02h)", last, want.last, want.code));
    end
  endtask

  // anything still owed at the end is a failure
  task finish_check();
    while (pending.size() != 0) begin
      ascii_char_t left;
      left = pending.pop_front();
      report($sformatf("missing char 0x%02h last=%0b", left.code, left.last));
    end
  endtask
endclass

module signed_int_to_decimal_ascii_test;
  import sitoa_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PER_PHASE = 100;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [DATA_W-1:0] s_axis_tdata_i = '0;    // value
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [7:0]        m_axis_tdata_o;         // char_code
  logic              m_axis_tlast_o;

  int              idle_pct = 0;
  int              stall_pct = 0;
  int              cycles = 0;
  ascii_scoreboard sb = new();

  // edges of the number ranges, powers of ten and the extremes
  int directed_values [22] = '{
    0, 1, -1, 5, 9, -9, 10, -10, 99, 100, -100, 999, 1000, -1000,
    9999, 10000, -10000, 12345, -12345, 32767, -32767, -32768
  };

  signed_int_to_decimal_ascii u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready_i <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // input and output item monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_value(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_char(m_axis_tdata_o, m_axis_tlast_o);
  end

  // offer one value, with random gaps first, and wait for its handshake
  task automatic send_value(input logic [DATA_W-1:0] word);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // sender holds off until every owed character has come out
  // the queue is checked only once the clock has risen, so the monitor has noted the last accepted value
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  // random values: full range, small numbers, digit-count edges, extremes
  task automatic run_phase(input int idle, input int stall, input int count);
    int v;
    int p;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: v = int'($urandom);
        1: v = int'($urandom_range(400)) - 200;
        2: begin
          p = 1;
          repeat ($urandom_range(4)) p = p * 10;
          v = p + int'($urandom_range(3)) - 2;
          if ($urandom_range(1)) v = -v;
        end
        default: v = $urandom_range(1) ? 32767 - int'($urandom_range(3))
                                       : -32768 + int'($urandom_range(3));
      endcase
      send_value(DATA_W'(v));
    end
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed values with no idling
    foreach (directed_values[i]) send_value(DATA_W'(directed_values[i]));
    wait_drained();

    run_phase(0, 0, RANDOM_PER_PHASE);
    run_phase(69, 0, RANDOM_PER_PHASE);
    run_phase(0, 69, RANDOM_PER_PHASE);
    run_phase(33, 33, RANDOM_PER_PHASE);

    // let any stray character show up before the final check
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.finish_check();

    $display("converted %0d values (%0d negative) into %0d characters",
             sb.values_seen, sb.negatives_seen, sb.chars_seen);
    $display("phases: free flow, idle sender, stalled receiver, both at once");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
